### rtl/core/pfd_pkg.sv
package pfd_pkg;

  localparam int ERR_W    = 17;
  localparam int STEP_W   = 28;
  localparam int DIFF50_W = 23;
  localparam int INTEG_W  = 32;
  localparam int DERIV_W  = 40;
  localparam int MA_W     = 25;
  localparam int MB_W     = 24;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int ACC_W    = 72;

  localparam logic [10:0] DT_Q16      = 11'd1311;
  localparam logic [5:0]  DERIV_SCALE = 6'd50;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_INTEG,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_F_DIFF,
    OP_F_LO,
    OP_F_HI,
    OP_KP,
    OP_KI_LO,
    OP_KI_HI,
    OP_KD_LO,
    OP_KD_HI
  } op_t;

  typedef enum logic [2:0] {
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_DRIVE_LIMIT,
    REG_INTEG_LIMIT,
    REG_SMOOTH_COEF
  } reg_idx_t;

  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_HIGH = 2'd1,
    SAT_LOW  = 2'd2
  } sat_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic integ;
    logic issue;
    op_t  op;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

### rtl/core/pid_filtered_derivative_antiwindup.sv
// Each item is taken in idle and passes prep, integrate, multiply-accumulate, drain
// and finish before the next is taken; the eight products of each step share one
// 25x24 multiplier, one product per cycle; finish waits while m_tvalid is unaccepted.
// s_tready is high in idle, also while an earlier result waits to be taken.
// Reset (rst, synchronous, active high) clears the integral, last measurement
// and filtered derivative and loads register defaults; no clearing pass.
module pid_filtered_derivative_antiwindup
  import pfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // target_value[15:0], measured_value[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // drive_value[15:0], zero[23:16]
  output logic [1:0]  m_tuser,   // saturation[1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [30:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pfd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/core/pfd_ctrl.sv
module pfd_ctrl
  import pfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [2:0] op_cnt, op_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_cnt <= '0;
    end else begin
      state  <= state_next;
      op_cnt <= op_cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_cnt_next = op_cnt;
    s_tready    = 1'b0;
    cmd         = '{load: 1'b0, prep: 1'b0, integ: 1'b0, issue: 1'b0,
                    op: OP_F_DIFF, finish: 1'b0};
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        cmd.issue   = 1'b1;
        cmd.op      = op_t'(op_cnt);
        op_cnt_next = op_cnt + 3'd1;
        if (op_t'(op_cnt) == OP_KD_HI) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (op_cnt == '0))
    else $error("operation counter not home in idle");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("controller did not return to idle after finish");

endmodule

### rtl/core/pfd_datapath.sv
module pfd_datapath
  import pfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [31:0] s_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [30:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic [1:0]  m_tuser
);

  logic [23:0] gain_prop, gain_integ, gain_deriv;
  logic [14:0] drive_limit;
  logic [30:0] integ_limit;
  logic [16:0] smooth_coef;

  logic signed [ERR_W-1:0]    err_r, diff_r;
  logic signed [15:0]         last_measure;
  logic signed [STEP_W-1:0]   step_r;
  logic signed [DIFF50_W-1:0] diff50_r;
  logic signed [INTEG_W-1:0]  integ_sum;
  logic signed [DERIV_W-1:0]  deriv_smoothed;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod_r;
  op_t                        tag_r;
  logic                       tag_vld;
  logic signed [15:0]         out_drive;
  sat_t                       out_sat;

  logic signed [15:0]       tgt, meas;
  logic [16:0]              a_eff, a_inv;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, term, acc_sum, lim_q;
  logic signed [STEP_W-1:0] err_ext, dt_ext;
  logic signed [DIFF50_W-1:0] diff_ext, scale_ext;
  logic signed [32:0]       int33, lim33, unw33, step33;
  logic signed [INTEG_W-1:0] integ_clamped, integ_unwound;
  logic                     sat_hi, sat_lo, trunc_adj;
  logic [15:0]              drive_trunc;

  assign tgt  = $signed(s_tdata[15:0]);
  assign meas = $signed(s_tdata[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= '0;
      gain_integ  <= '0;
      gain_deriv  <= '0;
      drive_limit <= 15'h7FFF;
      integ_limit <= 31'h7FFF_FFFF;
      smooth_coef <= 17'(DT_Q16);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_PROP:   gain_prop   <= cfg_data[23:0];
        REG_GAIN_INTEG:  gain_integ  <= cfg_data[23:0];
        REG_GAIN_DERIV:  gain_deriv  <= cfg_data[23:0];
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[14:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[30:0];
        REG_SMOOTH_COEF: smooth_coef <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign a_eff = (smooth_coef > ONE_Q16) ? ONE_Q16 : smooth_coef;
  assign a_inv = ONE_Q16 - a_eff;

  assign err_ext   = {{(STEP_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign dt_ext    = $signed({{(STEP_W-11){1'b0}}, DT_Q16});
  assign diff_ext  = {{(DIFF50_W-ERR_W){diff_r[ERR_W-1]}}, diff_r};
  assign scale_ext = $signed({{(DIFF50_W-6){1'b0}}, DERIV_SCALE});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_F_DIFF: begin
        ma = $signed({8'b0, a_inv});
        mb = {diff50_r[DIFF50_W-1], diff50_r};
      end
      OP_F_LO: begin
        ma = $signed({8'b0, a_eff});
        mb = $signed({4'b0, deriv_smoothed[19:0]});
      end
      OP_F_HI: begin
        ma = $signed({8'b0, a_eff});
        mb = {{4{deriv_smoothed[39]}}, deriv_smoothed[39:20]};
      end
      OP_KP: begin
        ma = $signed({1'b0, gain_prop});
        mb = {{7{err_r[ERR_W-1]}}, err_r};
      end
      OP_KI_LO: begin
        ma = $signed({1'b0, gain_integ});
        mb = $signed({8'b0, integ_sum[15:0]});
      end
      OP_KI_HI: begin
        ma = $signed({1'b0, gain_integ});
        mb = {{8{integ_sum[31]}}, integ_sum[31:16]};
      end
      OP_KD_LO: begin
        ma = $signed({1'b0, gain_deriv});
        mb = $signed({4'b0, deriv_smoothed[19:0]});
      end
      OP_KD_HI: begin
        ma = $signed({1'b0, gain_deriv});
        mb = {{4{deriv_smoothed[39]}}, deriv_smoothed[39:20]};
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (tag_r)
      OP_F_DIFF, OP_KP, OP_KI_HI: term = prod_ext <<< 16;
      OP_F_HI, OP_KD_HI:          term = prod_ext <<< 20;
      default:                    term = prod_ext;
    endcase
    if (tag_r == OP_KD_LO || tag_r == OP_KD_HI) begin
      acc_sum = acc - term;
    end else begin
      acc_sum = acc + term;
    end
  end

  assign step33 = {{(33-STEP_W){step_r[STEP_W-1]}}, step_r};
  assign int33  = {integ_sum[31], integ_sum} + step33;
  assign lim33  = $signed({2'b0, integ_limit});

  function automatic logic signed [INTEG_W-1:0] integ_limit_ext(logic signed [32:0] v);
    return v[31:0];
  endfunction

  always_comb begin
    if (int33 > lim33) begin
      integ_clamped = integ_limit_ext(lim33);
    end else if (int33 < -lim33) begin
      integ_clamped = integ_limit_ext(-lim33);
    end else begin
      integ_clamped = int33[31:0];
    end
  end

  assign unw33 = {integ_sum[31], integ_sum} - step33;

  always_comb begin
    if (unw33[32] != unw33[31]) begin
      integ_unwound = unw33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_unwound = unw33[31:0];
    end
  end

  assign lim_q       = $signed({{(ACC_W-47){1'b0}}, drive_limit, 32'b0});
  assign sat_hi      = acc > lim_q;
  assign sat_lo      = acc < -lim_q;
  assign trunc_adj   = acc[ACC_W-1] && (acc[31:0] != 32'b0);
  assign drive_trunc = acc[47:32] + {15'b0, trunc_adj};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_measure   <= '0;
      integ_sum      <= '0;
      deriv_smoothed <= '0;
      tag_vld        <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      tag_vld <= cmd.issue;
      if (cmd.load) begin
        last_measure <= meas;
      end
      if (cmd.integ) begin
        integ_sum <= integ_clamped;
      end else if (cmd.finish && (sat_hi || sat_lo)) begin
        integ_sum <= integ_unwound;
      end
      if (tag_vld && tag_r == OP_F_HI) begin
        deriv_smoothed <= acc_sum[16 +: DERIV_W];
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= {tgt[15], tgt} - {meas[15], meas};
      diff_r <= {meas[15], meas} - {last_measure[15], last_measure};
    end
    if (cmd.prep) begin
      step_r   <= err_ext * dt_ext;
      diff50_r <= diff_ext * scale_ext;
      acc      <= '0;
    end else if (tag_vld) begin
      if (tag_r == OP_F_HI) begin
        acc <= '0;
      end else begin
        acc <= acc_sum;
      end
    end
    if (cmd.issue) begin
      prod_r <= prod;
      tag_r  <= cmd.op;
    end
    if (cmd.finish) begin
      if (sat_hi) begin
        out_drive <= $signed({1'b0, drive_limit});
        out_sat   <= SAT_HIGH;
      end else if (sat_lo) begin
        out_drive <= -$signed({1'b0, drive_limit});
        out_sat   <= SAT_LOW;
      end else begin
        out_drive <= $signed(drive_trunc);
        out_sat   <= SAT_NONE;
      end
    end
  end

  assign status.out_full = m_tvalid && !m_tready;
  assign m_tdata         = {8'b0, out_drive};
  assign m_tuser         = out_sat;

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !tag_vld)
    else $error("item taken while a product is in flight");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished item not presented");

endmodule

### verif/pid_filtered_derivative_antiwindup_tb.sv
`timescale 1ns / 100ps

module pid_filtered_derivative_antiwindup_tb;
  import pfd_pkg::*;

  localparam longint STEP_DT     = 1311;
  localparam longint D_SCALE     = 50;
  localparam longint UNITY16     = 65536;
  localparam longint UNITY32     = 64'h1_0000_0000;
  localparam longint INT32_HI    = 2147483647;
  localparam longint INT32_LO    = -64'sd2147483648;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     HOLD_LEN    = 300;
  localparam int     REPORT_CAP  = 200;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] target;
  } ctl_item_t;

  typedef struct {
    logic [15:0] drive;
    sat_t        sat;
  } drive_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // target_value[15:0], measured_value[31:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // drive_value[15:0], zero[23:16]
  logic [1:0]  m_tuser;        // saturation[1:0]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [30:0] cfg_data = '0;

  longint kp = 0, ki = 0, kd = 0;
  longint out_lim = 32767, int_lim = 2147483647, filt_a = 1311;
  longint integ_acc = 0, prev_meas = 0, deriv_filt = 0;

  ctl_item_t  ctl_pending_q[$];
  drive_res_t drive_expect_q[$];
  drive_res_t exp_r;

  int  errors = 0;
  int  results_got = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  hold_left = 0;
  int  quiet = 0;
  bit  idle_on = 1'b1;
  int  limit_vals[5] = '{-32768, -1, 0, 1, 32767};

  pid_filtered_derivative_antiwindup DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic predict_drive(input ctl_item_t it);
    longint err, stp, acc, raw, a, sum, drv;
    drive_res_t res;
    err = longint'(it.target) - longint'(it.measured);
    stp = err * STEP_DT;
    acc = integ_acc + stp;
    if (acc > int_lim) acc = int_lim;
    if (acc < -int_lim) acc = -int_lim;
    integ_acc = acc;
    raw = (longint'(it.measured) - prev_meas) * D_SCALE * UNITY16;
    a = (filt_a > UNITY16) ? UNITY16 : filt_a;
    deriv_filt = (a * deriv_filt + (UNITY16 - a) * raw) >>> 16;
    sum = kp * err * UNITY16 + ki * integ_acc - kd * deriv_filt;
    res.sat = SAT_NONE;
    if (sum > out_lim * UNITY32) begin
      drv = out_lim;
      res.sat = SAT_HIGH;
    end else if (sum < -out_lim * UNITY32) begin
      drv = -out_lim;
      res.sat = SAT_LOW;
    end else begin
      drv = sum / UNITY32;
    end
    if (res.sat != SAT_NONE) begin
      acc = integ_acc - stp;
      if (acc > INT32_HI) acc = INT32_HI;
      if (acc < INT32_LO) acc = INT32_LO;
      integ_acc = acc;
    end
    prev_meas = longint'(it.measured);
    res.drive = drv[15:0];
    drive_expect_q.push_back(res);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint pick_val(input int w);
    int r;
    longint full;
    r = $urandom_range(0, 9);
    full = (64'sd1 <<< w) - 1;
    if (r == 0) return 0;
    if (r == 1) return full;
    return (longint'({$urandom, $urandom}) & full) >> $urandom_range(0, w - 1);
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_GAIN_PROP:   kp = longint'(val[23:0]);
      REG_GAIN_INTEG:  ki = longint'(val[23:0]);
      REG_GAIN_DERIV:  kd = longint'(val[23:0]);
      REG_DRIVE_LIMIT: out_lim = longint'(val[14:0]);
      REG_INTEG_LIMIT: int_lim = longint'(val[30:0]);
      REG_SMOOTH_COEF: filt_a = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  task automatic apply_regs(input longint g_p, input longint g_i, input longint g_d,
                            input longint d_lim, input longint i_lim, input longint coef);
    if ($urandom_range(0, 2) == 0)
      set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 31'($urandom));
    set_reg(REG_GAIN_PROP, 31'(g_p));
    set_reg(REG_GAIN_INTEG, 31'(g_i));
    set_reg(REG_GAIN_DERIV, 31'(g_d));
    set_reg(REG_DRIVE_LIMIT, 31'(d_lim));
    set_reg(REG_INTEG_LIMIT, 31'(i_lim));
    set_reg(REG_SMOOTH_COEF, 31'(coef));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_item(input int t, input int m);
    ctl_pending_q.push_back('{measured: 16'(m), target: 16'(t)});
  endtask

  task automatic wait_drained();
    while (ctl_pending_q.size() != 0 || drive_expect_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // mostly settling trajectories towards a fixed setpoint, the rest noise and corners
  task automatic fill_random(input int n);
    int k, len, i, tg, ms, span;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          push_item($urandom, $urandom);
          k++;
        end
        2: begin
          push_item(limit_vals[$urandom_range(0, 4)], limit_vals[$urandom_range(0, 4)]);
          k++;
        end
        default: begin
          len  = $urandom_range(4, 24);
          tg   = int'($signed(16'($urandom)));
          ms   = int'($signed(16'($urandom)));
          span = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 4096);
          for (i = 0; i < len; i++) begin
            push_item(tg, ms);
            ms = ms + ((tg - ms) >>> 3) + int'($urandom_range(0, 2 * span)) - span;
            if (ms > 32767) ms = 32767;
            if (ms < -32768) ms = -32768;
          end
          k += len;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_drive(ctl_pending_q.pop_front());
        tx_gap = idle_on ? pick_gap() : 0;
      end
      if (s_tvalid && !s_tready) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (ctl_pending_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= ctl_pending_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_expect_q.size() == 0) begin
          if (errors < REPORT_CAP)
            $display("%0t: unexpected result drive=%0d sat=%0d", $time,
                     $signed(m_tdata[15:0]), m_tuser);
          errors++;
        end else begin
          exp_r = drive_expect_q.pop_front();
          if (m_tdata !== {8'h00, exp_r.drive} || m_tuser !== exp_r.sat) begin
            if (errors < REPORT_CAP)
              $display("%0t: mismatch expected drive=%0d sat=%0d, actual tdata=%h sat=%0d",
                       $time, $signed(exp_r.drive), exp_r.sat, m_tdata, m_tuser);
            errors++;
          end
        end
        results_got++;
        if (results_got % 600 == 250) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("pid_filtered_derivative_antiwindup_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults: all gains zero
    push_item(0, 0);
    push_item(32767, -32768);
    wait_drained();

    set_reg(REG_SPARE_A, '1);
    set_reg(REG_SPARE_B, '1);
    apply_regs(65536, 262144, 16384, 2000, 50 * 65536, 1311);
    push_item(32767, -32768);
    push_item(-32768, 32767);
    push_item(0, 0);
    push_item(-1, 0);
    push_item(1, 0);
    push_item(32767, 32767);
    push_item(-32768, -32768);
    push_item(100, -100);
    wait_drained();

    // zero output limit, filter weight above one
    apply_regs(16777215, 0, 0, 0, 2147483647, 131071);
    push_item(0, 0);
    push_item(5, 4);
    push_item(4, 5);
    push_item(-32768, 32767);
    push_item(32767, -32768);
    wait_drained();

    apply_regs(0, 0, 65536, 32767, 2147483647, 65537);
    push_item(0, 100);
    push_item(0, -100);
    push_item(0, 0);
    wait_drained();

    for (p = 0; p < 13; p++) begin
      idle_on = (p % 4 != 1);
      if (p == 0)
        apply_regs(16777215, 16777215, 16777215, 32767, 2147483647, 65536);
      else if (p == 1)
        apply_regs(0, 0, 0, 0, 0, 0);
      else
        apply_regs(pick_val(24), pick_val(24), pick_val(24), pick_val(15), pick_val(31),
                   pick_val(17));
      fill_random(100);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("pid_filtered_derivative_antiwindup_tb: PASS");
    else
      $display("pid_filtered_derivative_antiwindup_tb: FAIL");
    $finish;
  end

endmodule
